// ===== sv/hgba_pkg.sv =====
// package for the group-by aggregation table
// types, codes, hash constant and helpers; no dependencies
`timescale 1ns / 1ps

package hgba_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned KeyWidthDefault   = 32;
  localparam int unsigned BucketsLog2Reset  = 10;
  localparam int unsigned BucketsLog2Min    = 4;
  localparam int unsigned HashShift         = 64;
  localparam logic [63:0] HashMul           = 64'h9E3779B97F4A7C15;
  localparam logic [31:0] CntMax            = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_ACC   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_ACCUMULATED = 2'd0,
    ST_SKIPPED     = 2'd1,
    ST_DROPPED     = 2'd2,
    ST_DONE        = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic        key_present;
    logic [31:0] value;
    logic        value_present;
    logic [9:0]  bucket;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        entry_used;
    logic [31:0] out_key;
    logic [31:0] out_row_count;
    logic [31:0] out_pair_count;
    logic [63:0] out_sum;
    logic [31:0] out_min;
    logic [31:0] out_max;
  } out_word_t;

  // aggregate carried by a group
  typedef struct packed {
    logic [31:0] row_count;
    logic [31:0] pair_count;
    logic [63:0] sum;
    logic [31:0] min;
    logic [31:0] max;
  } agg_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == CntMax) ? c : c + 32'd1;
  endfunction

endpackage

// ===== sv/hgba_cell.sv =====
// one lane of the 16-bit partial-product chain used for the hash multiply
// depends on hgba_pkg
`timescale 1ns / 1ps

module hgba_cell
  import hgba_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] acc_in,
  input  logic [15:0] key_part,
  input  logic [5:0]  shift,
  output logic [63:0] acc_out
);

  logic [63:0] prod;

  // 16 x 64 partial product, only bits below 2^64 matter
  assign prod = (64'(key_part) * HashMul) << shift;

  always_ff @(posedge clk) begin
    acc_out <= acc_in + prod;
  end

endmodule

// ===== sv/hash_group_by_aggregator_unit.sv =====
// top level of the group-by aggregation table
// depends on hgba_pkg and hgba_cell (chain of hash partial-product cells)
`timescale 1ns / 1ps
//
//  channel  | signals                      | handshake
//  ---------+------------------------------+-----------------------------
//  command  | start, busy, in_word         | taken when start && !busy
//  result   | done, out_word               | one cycle strobe, no stall
//  config   | cfg_we, cfg_data             | written when cfg_we high
//
//  a row keeps busy high through the hash chain, then a memory read and a
//  check/write per bucket probed, then the output state.
//  reads are busy for a read state and the output state, skipped rows and the
//  unused mode for the output state only. clear sweeps all TABLE_DEPTH buckets before its output state.
//  reset and config writes run the same sweep with busy high and no result.
//  done strobes in the cycle busy falls; results cannot be stalled.

module hash_group_by_aggregator_unit
  import hgba_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned KEY_WIDTH   = KeyWidthDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      done,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic [3:0] cfg_data
);

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned KWU = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam logic [3:0]  LgTop = 4'(AW);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HASH  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_RDOUT = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_CLR   = 7'b1000000
  } state_t;

  state_t state;
  logic [3:0] buckets_log2;
  logic [3:0] lg;
  logic [AW:0] nb;
  in_word_t cmd;
  logic [2:0] hcnt;
  logic [AW-1:0] pos;
  logic [AW:0] probes;
  logic clr_ack;

  logic [31:0] mem_key  [TABLE_DEPTH];
  agg_t        mem_agg  [TABLE_DEPTH];
  logic        mem_used [TABLE_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [31:0] rd_key;
  agg_t        rd_agg;
  logic        rd_used;
  logic        wr_en;
  logic [31:0] wr_key;
  agg_t        wr_agg;
  agg_t        upd;

  logic [31:0] key_m;
  logic [63:0] acc [5];
  logic [63:0] hash;

  function automatic out_word_t status_word(input status_t s);
    status_word = '0;
    status_word.status = s;
  endfunction

  assign lg = (buckets_log2 < 4'(BucketsLog2Min)) ? 4'(BucketsLog2Min) :
              (buckets_log2 > LgTop) ? LgTop : buckets_log2;
  assign nb = (AW+1)'(1) << lg;

  assign key_m = cmd.key & ((KWU == 32) ? 32'hFFFF_FFFF : ((32'd1 << KWU) - 32'd1));

  // chain of four cells; the first two add the 16-bit slices of the key, the last two add zero
  assign acc[0] = '0;
  for (genvar g = 0; g < 4; g++) begin : g_chain
    logic [15:0] part;
    assign part = (g < 2) ? key_m[16*(g%2) +: 16] : 16'd0;
    hgba_cell u_cell (
      .clk     (clk),
      .acc_in  (acc[g]),
      .key_part(part),
      .shift   (6'(16*g)),
      .acc_out (acc[g+1])
    );
  end
  assign hash = acc[4];

  assign busy = (state != S_IDLE) || cfg_we;

  assign rd_addr = (state == S_IDLE) ? AW'(in_word.bucket) : pos;

  // memory ports; the used flags are swept to zero by the clear pass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[pos]  <= wr_key;
      mem_agg[pos]  <= wr_agg;
      mem_used[pos] <= 1'b1;
    end else if (state == S_CLR) begin
      mem_used[pos] <= 1'b0;
    end
    rd_key  <= mem_key[rd_addr];
    rd_agg  <= mem_agg[rd_addr];
    rd_used <= mem_used[rd_addr];
  end

  always_comb begin
    upd = rd_used ? rd_agg : '0;
    upd.row_count = sat_inc(upd.row_count);
    if (cmd.value_present) begin
      if (upd.pair_count == 32'd0) begin
        upd.min = cmd.value;
        upd.max = cmd.value;
      end else begin
        if (cmd.value < upd.min) upd.min = cmd.value;
        if (cmd.value > upd.max) upd.max = cmd.value;
      end
      upd.pair_count = sat_inc(upd.pair_count);
      upd.sum = upd.sum + 64'(cmd.value);
    end
  end

  assign wr_en  = (state == S_CHK) && (!rd_used || rd_key == key_m);
  assign wr_key = key_m;
  assign wr_agg = upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      buckets_log2 <= 4'(BucketsLog2Reset);
      pos          <= '0;
      clr_ack      <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      if (cfg_we) begin
        buckets_log2 <= cfg_data;
        pos          <= '0;
        clr_ack      <= 1'b0;
        state        <= S_CLR;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (start) begin
              cmd    <= in_word;
              hcnt   <= '0;
              probes <= '0;
              unique case (mode_t'(in_word.mode))
                MODE_ACC: begin
                  if (in_word.key_present) begin
                    out_word <= '0;
                    state    <= S_HASH;
                  end else begin
                    out_word <= status_word(ST_SKIPPED);
                    state    <= S_OUT;
                  end
                end
                MODE_READ: begin
                  out_word <= status_word(ST_DONE);
                  state    <= S_RDOUT;
                end
                MODE_CLEAR: begin
                  out_word <= status_word(ST_DONE);
                  pos      <= '0;
                  clr_ack  <= 1'b1;
                  state    <= S_CLR;
                end
                MODE_NONE: begin
                  out_word <= status_word(ST_DONE);
                  state    <= S_OUT;
                end
              endcase
            end
          end
          S_HASH: begin
            hcnt <= hcnt + 3'd1;
            if (hcnt == 3'd4) begin
              pos   <= AW'(hash >> (7'(HashShift) - 7'(lg)));
              state <= S_RD;
            end
          end
          S_RD: begin
            state <= S_CHK;
          end
          S_CHK: begin
            if (wr_en) begin
              out_word.status <= ST_ACCUMULATED;
              state <= S_OUT;
            end else if (probes + (AW+1)'(1) == nb) begin
              out_word.status <= ST_DROPPED;
              state <= S_OUT;
            end else begin
              probes <= probes + (AW+1)'(1);
              pos    <= (pos + AW'(1)) & AW'(nb - (AW+1)'(1));
              state  <= S_RD;
            end
          end
          S_RDOUT: begin
            if ((AW+1)'(cmd.bucket) < nb && 32'(cmd.bucket) < TABLE_DEPTH
                && rd_used) begin
              out_word <= {ST_DONE, 1'b1, rd_key, rd_agg};
            end
            state <= S_OUT;
          end
          S_OUT: begin
            state <= S_IDLE;
          end
          S_CLR: begin
            if (pos == AW'(TABLE_DEPTH - 1)) begin
              state <= clr_ack ? S_OUT : S_IDLE;
            end else begin
              pos <= pos + AW'(1);
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result outside idle");
  a_wr_chk: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_CHK) else $error("write outside check");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> probes < nb) else $error("probe overrun");

endmodule

// ===== test/tb.sv =====
// testbench for the group-by aggregation table top level
// depends on hgba_pkg and hash_group_by_aggregator_unit; self-checking, no files
`timescale 1ns / 1ps

module tb;
  import hgba_pkg::*;

  localparam int unsigned Depth = 1024;
  localparam int unsigned WatchLimit = 20000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_word_t in_word;
  logic done;
  out_word_t out_word;
  logic cfg_we;
  logic [3:0] cfg_data;

  hash_group_by_aggregator_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .done(done), .out_word(out_word), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [3:0]  lg_reg;
  logic        grp_valid [Depth];
  logic [31:0] grp_key   [Depth];
  agg_t        grp_agg   [Depth];

  in_word_t  pending_words [$];
  out_word_t expected_words [$];
  int errors;
  int idle_pct;
  int watch;
  bit stim_done;
  logic busy_q;
  logic taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned lg_in_use();
    if (lg_reg < BucketsLog2Min) return BucketsLog2Min;
    if (lg_reg > 10) return 10;
    return lg_reg;
  endfunction

  function automatic void wipe_groups();
    for (int i = 0; i < Depth; i++) grp_valid[i] = 1'b0;
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    int unsigned lg;
    int unsigned nb;
    int unsigned s;
    logic [63:0] prod;
    logic [9:0] home;
    bit placed;
    r = '0;
    lg = lg_in_use();
    nb = 1 << lg;
    case (mode_t'(w.mode))
      MODE_ACC: begin
        if (!w.key_present) begin
          r.status = ST_SKIPPED;
          return r;
        end
        prod = {32'd0, w.key} * HashMul;
        home = 10'(prod >> (64 - lg));
        placed = 0;
        for (int i = 0; i < nb && !placed; i++) begin
          s = (home + i) & (nb - 1);
          if (!grp_valid[s]) begin
            grp_valid[s] = 1'b1;
            grp_key[s] = w.key;
            grp_agg[s] = '0;
          end
          if (grp_key[s] == w.key) begin
            placed = 1;
            grp_agg[s].row_count = (grp_agg[s].row_count == CntMax) ?
                CntMax : grp_agg[s].row_count + 1;
            if (w.value_present) begin
              if (grp_agg[s].pair_count == 0) begin
                grp_agg[s].min = w.value;
                grp_agg[s].max = w.value;
              end else begin
                if (w.value < grp_agg[s].min) grp_agg[s].min = w.value;
                if (w.value > grp_agg[s].max) grp_agg[s].max = w.value;
              end
              grp_agg[s].pair_count = (grp_agg[s].pair_count == CntMax) ?
                  CntMax : grp_agg[s].pair_count + 1;
              grp_agg[s].sum = grp_agg[s].sum + {32'd0, w.value};
            end
          end
        end
        r.status = placed ? ST_ACCUMULATED : ST_DROPPED;
      end
      MODE_READ: begin
        r.status = ST_DONE;
        if (w.bucket < nb && grp_valid[w.bucket]) begin
          r.entry_used = 1'b1;
          r.out_key = grp_key[w.bucket];
          r.out_row_count = grp_agg[w.bucket].row_count;
          r.out_pair_count = grp_agg[w.bucket].pair_count;
          r.out_sum = grp_agg[w.bucket].sum;
          r.out_min = grp_agg[w.bucket].min;
          r.out_max = grp_agg[w.bucket].max;
        end
      end
      MODE_CLEAR: begin
        r.status = ST_DONE;
        wipe_groups();
      end
      default: r.status = ST_DONE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_q) begin
      // word taken at the last edge
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_word <= pending_words.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
      in_word <= pending_words.pop_front();
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    busy_q <= busy;
    taken = !rst && start && !busy;
    if (taken) expected_words.push_back(predict_word(in_word));
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result", out_word.status, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_word.status != want.status)
          report_mismatch("status", out_word.status, want.status);
        if (out_word.entry_used != want.entry_used)
          report_mismatch("entry_used", out_word.entry_used, want.entry_used);
        if (out_word.out_key != want.out_key)
          report_mismatch("out_key", out_word.out_key, want.out_key);
        if (out_word.out_row_count != want.out_row_count)
          report_mismatch("out_row_count", out_word.out_row_count, want.out_row_count);
        if (out_word.out_pair_count != want.out_pair_count)
          report_mismatch("out_pair_count", out_word.out_pair_count, want.out_pair_count);
        if (out_word.out_sum != want.out_sum)
          report_mismatch("out_sum", out_word.out_sum, want.out_sum);
        if (out_word.out_min != want.out_min)
          report_mismatch("out_min", out_word.out_min, want.out_min);
        if (out_word.out_max != want.out_max)
          report_mismatch("out_max", out_word.out_max, want.out_max);
      end
    end
  end

  // watchdog on cycles with nothing accepted and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      watch <= 0;
    end else if (!stim_done || expected_words.size() > 0 || pending_words.size() > 0) begin
      watch <= watch + 1;
      if (watch >= WatchLimit) begin
        $display("hash_group_by_aggregator_unit verification failed");
        $finish;
      end
    end
  end

  function automatic in_word_t make_word(input mode_t m, input logic [31:0] k,
                                         input logic kp, input logic [31:0] v,
                                         input logic vp, input logic [9:0] b);
    in_word_t w;
    w.mode = m;
    w.key = k;
    w.key_present = kp;
    w.value = v;
    w.value_present = vp;
    w.bucket = b;
    return w;
  endfunction

  function automatic in_word_t rand_word(input int unsigned nkeys);
    in_word_t w;
    int unsigned p;
    w = make_word(MODE_ACC, $urandom_range(nkeys - 1), 1'b1, $urandom, $urandom_range(3) != 0,
                  10'($urandom));
    p = $urandom_range(99);
    if (p < 6) w.key = $urandom;
    else if (p < 10) w.key_present = 1'b0;
    else if (p < 25) w.mode = MODE_READ;
    else if (p < 26) w.mode = MODE_CLEAR;
    else if (p < 28) w.mode = MODE_NONE;
    if ($urandom_range(9) == 0) w.value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
    return w;
  endfunction

  // let every queued word finish and its result be checked
  task automatic drain();
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (start || expected_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_lg(input logic [3:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    lg_reg = v;
    wipe_groups();
  endtask

  initial begin
    logic [3:0] lg_set [6];
    rst = 1'b1;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0;
    idle_pct = 22;
    stim_done = 0;
    lg_reg = BucketsLog2Reset;
    wipe_groups();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed words on the reset size
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'd0));
    pending_words.push_back(make_word(MODE_ACC, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 10'h3FF));
    pending_words.push_back(make_word(MODE_ACC, 32'hFFFF_FFFF, 1, 32'd0, 1, 10'd0));
    pending_words.push_back(make_word(MODE_ACC, 32'hFFFF_FFFF, 1, 32'd5, 0, 10'd0));
    pending_words.push_back(make_word(MODE_ACC, 32'd0, 1, 32'd7, 0, 10'd0));
    pending_words.push_back(make_word(MODE_ACC, 32'd0, 1, 32'd9, 1, 10'd0));
    pending_words.push_back(make_word(MODE_ACC, 32'd1, 0, 32'hFFFF_FFFF, 1, 10'h3FF));
    pending_words.push_back(make_word(MODE_NONE, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 10'h3FF));
    for (int b = 0; b < 1024; b += 97)
      pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'(b)));
    pending_words.push_back(make_word(MODE_CLEAR, 0, 1, 0, 1, 0));
    pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0, 10'h3FF));
    // sender waits for every result
    drain();

    // sizes including the extremes and clamped codes
    lg_set = '{4'd4, 4'd15, 4'd0, 4'd7, 4'd10, 4'd5};
    foreach (lg_set[j]) begin
      write_lg(lg_set[j]);
      idle_pct = (j == 3) ? 0 : 22;
      // fill past capacity on the smallest size to reach the table-full case
      for (int n = 0; n < 260; n++)
        pending_words.push_back(rand_word((j == 0 || j == 2) ? 24 : 40));
      for (int b = 0; b < 16; b++)
        pending_words.push_back(make_word(MODE_READ, 0, 0, 0, 0,
                                          10'(b + (b == 15 ? 1000 : 0))));
    end
    drain();
    stim_done = 1;
    if (errors == 0) begin
      $display("hash_group_by_aggregator_unit verification clean");
    end else begin
      $display("hash_group_by_aggregator_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== hash_group_by_aggregator_unit.f =====
sv/hgba_pkg.sv
sv/hgba_cell.sv
sv/hash_group_by_aggregator_unit.sv
test/tb.sv
